/* sv/bsl_pkg.sv */
// ----------------------------------------------------------------------------
// bsl_pkg: shared types and constants for the bitonic run length block
// Holds the token that walks the tail cell chain and the fixed field widths.
// ----------------------------------------------------------------------------
package bsl_pkg;

  // Default number of tail cells in each store.
  localparam int unsigned MAX_LEN_DEFAULT = 256;

  // Run length width, wide enough for the largest supported store (4096).
  localparam int unsigned LEN_W = 13;

  // Width of an input value and of the result length.
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned BEST_W  = 9;

  // Largest result length; larger sums saturate here.
  localparam logic [BEST_W-1:0] BEST_MAX = '1;

  // One request travelling down the chain together with its partial results.
  typedef struct packed {
    logic                       valid;
    logic                       last;
    logic signed [VALUE_W-1:0]  key;
    logic                       rise_done;
    logic                       fall_done;
    logic [LEN_W-1:0]           rise_len;
    logic [LEN_W-1:0]           fall_len;
  } token_t;

endpackage

/* sv/bsl_cell.sv */
// ----------------------------------------------------------------------------
// bsl_cell: one tail cell of both patience stores
// Holds the rising and falling tail of one run length and places a passing
// request when the tail is the first one that does not lie before it.
// ----------------------------------------------------------------------------
module bsl_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  bsl_pkg::token_t tok_in,
  output bsl_pkg::token_t tok_out
);

  localparam int unsigned LW = bsl_pkg::LEN_W;
  localparam logic [LW-1:0] CELL_LEN = LW'(INDEX + 1);

  logic                               rise_valid;
  logic                               fall_valid;
  logic signed [bsl_pkg::VALUE_W-1:0] rise_tail;
  logic signed [bsl_pkg::VALUE_W-1:0] fall_tail;

  logic                               rise_valid_next;
  logic                               fall_valid_next;
  logic signed [bsl_pkg::VALUE_W-1:0] rise_tail_next;
  logic signed [bsl_pkg::VALUE_W-1:0] fall_tail_next;
  bsl_pkg::token_t                    tok_next;
  logic                               rise_hit;
  logic                               fall_hit;

  // A request stops in the first cell whose tail is empty or not strictly before it.
  assign rise_hit = !tok_in.rise_done && (!rise_valid || !(rise_tail < tok_in.key));
  assign fall_hit = !tok_in.fall_done && (!fall_valid || !(fall_tail > tok_in.key));

  // Place the request, and let the final request of a sequence empty the cell.
  always_comb begin
    tok_next        = tok_in;
    rise_valid_next = rise_valid;
    fall_valid_next = fall_valid;
    rise_tail_next  = rise_tail;
    fall_tail_next  = fall_tail;
    if (tok_in.valid) begin
      if (rise_hit) begin
        rise_tail_next     = tok_in.key;
        rise_valid_next    = 1'b1;
        tok_next.rise_done = 1'b1;
        tok_next.rise_len  = CELL_LEN;
      end
      if (fall_hit) begin
        fall_tail_next     = tok_in.key;
        fall_valid_next    = 1'b1;
        tok_next.fall_done = 1'b1;
        tok_next.fall_len  = CELL_LEN;
      end
      if (tok_in.last) begin
        rise_valid_next = 1'b0;
        fall_valid_next = 1'b0;
      end
    end
  end

  // Control state of the cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      rise_valid    <= 1'b0;
      fall_valid    <= 1'b0;
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      rise_valid <= rise_valid_next;
      fall_valid <= fall_valid_next;
      tok_out    <= tok_next;
    end
  end

  // Tail values need no reset; they are read only while marked valid.
  always_ff @(posedge clk) begin
    if (advance) begin
      rise_tail <= rise_tail_next;
      fall_tail <= fall_tail_next;
    end
  end

`ifndef NO_ASSERTIONS
  // The final request of a sequence leaves the cell empty for the next one.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && tok_in.valid && tok_in.last) |=> (!rise_valid && !fall_valid))
    else $error("cell not emptied by final request");

  // A request already placed in the rising store keeps its length.
  a_rise_kept: assert property (@(posedge clk) disable iff (rst)
    (advance && tok_in.valid && tok_in.rise_done)
      |=> (tok_out.rise_len == $past(tok_in.rise_len)))
    else $error("placed rising length changed");

  // A request placed here carries this cell's length onward.
  a_rise_len: assert property (@(posedge clk) disable iff (rst)
    (advance && tok_in.valid && rise_hit) |=> (tok_out.rise_done && tok_out.rise_len == CELL_LEN))
    else $error("rising length not set by placing cell");
`endif

endmodule

/* sv/bsl_accum.sv */
// ----------------------------------------------------------------------------
// bsl_accum: running maximum and result register
// Takes requests leaving the cell chain, keeps the best sum of both run
// lengths minus one and the overflow mark, and holds the result for output.
// ----------------------------------------------------------------------------
module bsl_accum (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  bsl_pkg::token_t             tok,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bsl_pkg::BEST_W-1:0]  out_best,
  output logic                        out_overflow
);

  localparam int unsigned SW = bsl_pkg::LEN_W + 1;

  logic [bsl_pkg::BEST_W-1:0] best;
  logic                       ovf_seen;
  logic [SW-1:0]              sum;
  logic [bsl_pkg::BEST_W-1:0] sum_sat;
  logic [bsl_pkg::BEST_W-1:0] best_next;
  logic                       ovf_next;
  logic                       take;

  // Sum of both lengths minus one, saturated to the result width.
  assign sum     = {1'b0, tok.rise_len} + {1'b0, tok.fall_len} - SW'(1);
  assign sum_sat = (sum > SW'(bsl_pkg::BEST_MAX)) ? bsl_pkg::BEST_MAX
                                                   : sum[bsl_pkg::BEST_W-1:0];
  assign best_next = (sum_sat > best) ? sum_sat : best;
  // A request that never found a cell ran off the end of a store.
  assign ovf_next  = ovf_seen || !tok.rise_done || !tok.fall_done;
  assign take      = advance && tok.valid;

  // Running maximum, cleared once a sequence ends.
  always_ff @(posedge clk) begin
    if (rst) begin
      best     <= '0;
      ovf_seen <= 1'b0;
    end else if (take) begin
      if (tok.last) begin
        best     <= '0;
        ovf_seen <= 1'b0;
      end else begin
        best     <= best_next;
        ovf_seen <= ovf_next;
      end
    end
  end

  // Result register; the chain stalls while a result is held and another is due.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && tok.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && tok.last) begin
      out_best     <= best_next;
      out_overflow <= ovf_next;
    end
  end

`ifndef NO_ASSERTIONS
  // The maximum starts over after each sequence.
  a_best_cleared: assert property (@(posedge clk) disable iff (rst)
    (take && tok.last) |=> (best == '0 && !ovf_seen))
    else $error("running maximum not cleared after final request");

  // A new result appears only because a final request left the chain.
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(take && tok.last))
    else $error("result without final request");

  // A held result is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(take && tok.last))
    else $error("pending result overwritten");
`endif

endmodule

/* sv/bitonic_subsequence_length.sv */
// ----------------------------------------------------------------------------
// bitonic_subsequence_length: longest bitonic run length by patience sorting
// A chain of tail cells holds both patience stores; each request walks the
// chain one cell per cycle unless held; best length is reported at sequence end.
//
//   channel  direction  fields (lowest bit first)
//   s_*      in         s_tdata: value[31:0]; s_tlast: last
//   m_*      out        m_tdata: best_length[8:0], zeros; m_tuser: overflow
//
// One request enters per cycle while s_tready is high. Its result, if marked
// last, raises m_tvalid once the request has crossed the MAX_LEN cell registers
// and then the result register. Reset empties every cell at once. While a
// result waits and another final request reaches the end of the chain, the
// whole chain holds and s_tready is low.
// ----------------------------------------------------------------------------
module bitonic_subsequence_length #(
  parameter int unsigned MAX_LEN = bsl_pkg::MAX_LEN_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value[31:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // best_length[8:0], zeros[15:9]
  output logic        m_tuser    // overflow
);

  localparam int unsigned LW = bsl_pkg::LEN_W;

  bsl_pkg::token_t            tok [0:MAX_LEN];
  logic                       advance;
  logic [bsl_pkg::BEST_W-1:0] out_best;

  // Hold the chain only when a final request meets a result still waiting.
  assign advance  = !(tok[MAX_LEN].valid && tok[MAX_LEN].last && m_tvalid && !m_tready);
  assign s_tready = advance;

  // A new request starts unplaced, with the overflow length as its default.
  always_comb begin
    tok[0].valid     = s_tvalid;
    tok[0].last      = s_tlast;
    tok[0].key       = $signed(s_tdata);
    tok[0].rise_done = 1'b0;
    tok[0].fall_done = 1'b0;
    tok[0].rise_len  = LW'(MAX_LEN);
    tok[0].fall_len  = LW'(MAX_LEN);
  end

  // Chain of tail cells, one per run length.
  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    bsl_cell #(
      .INDEX(i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .advance(advance),
      .tok_in (tok[i]),
      .tok_out(tok[i+1])
    );
  end

  // Running maximum and result register.
  bsl_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .tok         (tok[MAX_LEN]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_best    (out_best),
    .out_overflow(m_tuser)
  );

  assign m_tdata = {{(16 - bsl_pkg::BEST_W){1'b0}}, out_best};

endmodule
